// File: hdl/first_fit_range_allocator_core_macros.svh
// Assertion macros for the checker of the range allocator.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFRA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffra checker: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffra checker: assertion failed");

`endif

// File: hdl/ffra_pkg.sv
// Types and constants of the first-fit range allocator.
// Used by the top level and by its checker; depends on nothing.
package ffra_pkg;

   localparam int FIELD_W        = 16;
   localparam int REQ_TDATA_W    = 48;
   localparam int RSP_TDATA_W    = 24;
   localparam int STATUS_W       = 2;
   localparam int RSP_STATUS_LSB = FIELD_W;
   localparam int RSP_PAD_W      = RSP_TDATA_W - FIELD_W - STATUS_W;

   localparam logic OP_CLAIM = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ASCAN,
      ST_CSCAN,
      ST_SORT_TOP,
      ST_SORT_CARRY,
      ST_SORT_STEP,
      ST_SORT_LAST,
      ST_DONE
   } state_type;

endpackage

// File: hdl/ffra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the range table of the allocator; depends on nothing.
module ffra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/first_fit_range_allocator_core.sv
// First-fit range allocator.
// Channels: req_ takes one beat per item (claim an explicit range or allocate a
// gap of alloc_count indices); rsp_ returns exactly one beat per item with the
// start of the allocated gap (zero for claims) and a status code.
// Items are handled one at a time. The range table sits in one RAM with a
// registered read port, and the compare logic walks it one entry per cycle:
//   claim scan     over the stored ranges, N = number of stored ranges
//   allocate scan  over the stored ranges, before the claim scan
//   new entry      P passes over the table to restore sorted order; P is
//                  1 when the new range lands on top of an ordered table, 2 when
//                  it sinks into one, and at most N + 1 once extensions have
//                  left the table out of order
// plus the states that take the beat (ST_IDLE) and load the result (ST_DONE).
// The next request beat is taken as soon as the result sits in the output
// register; a stalled receiver only holds the block once a second result is
// ready. Reset empties the table at once (count back to zero, no sweep) and
// drops any pending result.
module first_fit_range_allocator_core
   import ffra_pkg::*;
#(
   parameter int MAX_RANGES = 32,
   parameter int INDEX_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // range_begin [15:0], range_end [31:16], alloc_count [47:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op [0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // start_index [15:0], status [17:16], zero [23:18]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int EW = 2 * INDEX_BITS;
   localparam int SW = ((INDEX_BITS > FIELD_W) ? INDEX_BITS : FIELD_W) + 1;
   localparam logic [SW-1:0] IDX_MAX_W = SW'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic [CW-1:0] CNT_FULL  = CW'(MAX_RANGES);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [FIELD_W-1:0]    cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0] key_b_ff, key_b_in;
   logic [INDEX_BITS-1:0] key_e_ff, key_e_in;
   logic [INDEX_BITS-1:0] base_ff, base_in;
   logic [FIELD_W-1:0]    start_ff, start_in;
   status_type            status_ff, status_in;
   logic [CW-1:0]         scan_idx_ff, scan_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [AW-1:0]         chk_idx_ff, chk_idx_in;
   logic [EW-1:0]         carry_ff, carry_in;
   logic [AW-1:0]         j_ff, j_in;
   logic                  swapped_ff, swapped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    rsp_start_ff, rsp_start_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [EW-1:0]         rd_data;

   logic [INDEX_BITS-1:0] rd_begin;
   logic [INDEX_BITS-1:0] rd_end;
   logic [SW-1:0]         rb_w;
   logic [SW-1:0]         re_w;
   logic [SW-1:0]         sum_w;
   logic                  scan_more;
   logic                  req_take;

   ffra_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_RANGES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_begin  = rd_data[EW-1:INDEX_BITS];
   assign rd_end    = rd_data[INDEX_BITS-1:0];
   assign rb_w      = SW'(req_tdata[FIELD_W-1:0]);
   assign re_w      = SW'(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign sum_w     = SW'(base_ff) + SW'(cnt_ff);
   assign scan_more = (scan_idx_ff < count_ff);
   assign req_take  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      key_b_ff      <= key_b_in;
      key_e_ff      <= key_e_in;
      base_ff       <= base_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      carry_ff      <= carry_in;
      j_ff          <= j_in;
      swapped_ff    <= swapped_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      key_b_in      = key_b_ff;
      key_e_in      = key_e_ff;
      base_in       = base_ff;
      start_in      = start_ff;
      status_in     = status_ff;
      scan_idx_in   = scan_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      carry_in      = carry_ff;
      j_in          = j_ff;
      swapped_in    = swapped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               scan_idx_in = '0;
               start_in    = '0;
               status_in   = STATUS_OK;
               if (req_tuser == OP_ALLOC) begin
                  cnt_in   = req_tdata[3*FIELD_W-1:2*FIELD_W];
                  base_in  = '0;
                  state_in = ST_ASCAN;
               end else if (rb_w > IDX_MAX_W || re_w > IDX_MAX_W) begin
                  status_in = STATUS_OVERFLOW;
                  state_in  = ST_DONE;
               end else begin
                  key_b_in = rb_w[INDEX_BITS-1:0];
                  key_e_in = re_w[INDEX_BITS-1:0];
                  state_in = ST_CSCAN;
               end
            end
         end

         ST_ASCAN: begin
            // The gap ends where an entry begins at or past base plus count.
            if ((chk_vld_ff && SW'(rd_begin) >= sum_w) || (!chk_vld_ff && !scan_more)) begin
               start_in    = FIELD_W'(base_ff);
               scan_idx_in = '0;
               if (sum_w > IDX_MAX_W) begin
                  status_in = STATUS_OVERFLOW;
                  state_in  = ST_DONE;
               end else begin
                  key_b_in = base_ff;
                  key_e_in = sum_w[INDEX_BITS-1:0];
                  state_in = ST_CSCAN;
               end
            end else begin
               if (chk_vld_ff) begin
                  base_in = rd_end;
               end
               if (scan_more) begin
                  rd_addr     = scan_idx_ff[AW-1:0];
                  chk_vld_in  = 1'b1;
                  chk_idx_in  = scan_idx_ff[AW-1:0];
                  scan_idx_in = scan_idx_ff + CW'(1);
               end
            end
         end

         ST_CSCAN: begin
            if (chk_vld_ff && rd_begin == key_e_ff) begin
               wr_en     = 1'b1;
               wr_addr   = chk_idx_ff;
               wr_data   = {key_b_ff, rd_end};
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end else if (chk_vld_ff && rd_end == key_b_ff) begin
               wr_en     = 1'b1;
               wr_addr   = chk_idx_ff;
               wr_data   = {rd_begin, key_e_ff};
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end else if (!chk_vld_ff && !scan_more) begin
               if (count_ff == CNT_FULL) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  // Append at the top, then bubble passes restore the order.
                  wr_en      = 1'b1;
                  wr_addr    = count_ff[AW-1:0];
                  wr_data    = {key_b_ff, key_e_ff};
                  count_in   = count_ff + CW'(1);
                  status_in  = STATUS_OK;
                  state_in   = (count_ff == '0) ? ST_DONE : ST_SORT_TOP;
               end
            end else if (scan_more) begin
               rd_addr     = scan_idx_ff[AW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff[AW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end

         ST_SORT_TOP: begin
            j_in       = AW'(count_ff - CW'(1));
            rd_addr    = j_in;
            swapped_in = 1'b0;
            state_in   = ST_SORT_CARRY;
         end

         ST_SORT_CARRY: begin
            carry_in = rd_data;
            rd_addr  = j_ff - AW'(1);
            state_in = ST_SORT_STEP;
         end

         ST_SORT_STEP: begin
            // The carried entry sinks only past a strictly larger one, which
            // keeps equal entries in their original order.
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (carry_ff < rd_data) begin
               wr_data    = rd_data;
               swapped_in = 1'b1;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            j_in = j_ff - AW'(1);
            if (j_ff == AW'(1)) begin
               state_in = ST_SORT_LAST;
            end else begin
               rd_addr = j_ff - AW'(2);
            end
         end

         ST_SORT_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = carry_ff;
            state_in = swapped_ff ? ST_SORT_TOP : ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = start_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_start_ff};

endmodule

// File: hdl/ffra_checker.sv
// Port-level checker for the first-fit range allocator, bound to the top level.
// Depends on ffra_pkg and on the shared assertion macro header.
`include "first_fit_range_allocator_core_macros.svh"

module ffra_checker
   import ffra_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   // start_index [15:0], status [17:16], zero [23:18]
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [1:0]          pending_ff, pending_in;
   logic                req_beat;
   logic                rsp_beat;
   logic [STATUS_W-1:0] rsp_status;

   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
   assign pending_in = pending_ff + 2'(req_beat) - 2'(rsp_beat);

   // Items taken whose result beat has not gone out yet.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `FFRA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The status codes are dense from zero, so the largest one bounds them.
   `FFRA_ASSERT_SAME(a_status_code, rsp_tvalid, rsp_status <= STATUS_OVERFLOW)

   `FFRA_ASSERT_NEXT(a_busy_after_take, req_beat, !req_tready)

   `FFRA_ASSERT_SAME(a_pending_bound, req_beat, pending_ff <= 2'd1)

endmodule

bind first_fit_range_allocator_core ffra_checker u_ffra_checker (.*);
